[rtl/sswt_pkg.sv]
`default_nettype none

package sswt_pkg;

    // Upper 12 bits of the four sync words.
    localparam logic [11:0] SW1_TOP = 12'hE24;
    localparam logic [11:0] SW2_TOP = 12'h1DA;
    localparam logic [11:0] SW3_TOP = 12'hE25;
    localparam logic [11:0] SW4_TOP = 12'h1DB;

    // Word numbers; a pair state carries the number of its first word.
    localparam logic [2:0] WORD_NONE = 3'd0;
    localparam logic [2:0] WORD_1    = 3'd1;
    localparam logic [2:0] WORD_2    = 3'd2;
    localparam logic [2:0] WORD_3    = 3'd3;
    localparam logic [2:0] WORD_4    = 3'd4;

    // Tracker states.
    localparam logic [2:0] TRK_IDLE = 3'd0;
    localparam logic [2:0] TRK_P12  = 3'd1;
    localparam logic [2:0] TRK_P23  = 3'd2;
    localparam logic [2:0] TRK_P34  = 3'd3;
    localparam logic [2:0] TRK_P41  = 3'd4;

    localparam logic [16:0] SUBFRAME_BITS_RST = 17'd3072;

    // Commands from the sequencer to the stamp store.
    typedef struct packed {
        logic wr_en;
        logic scan_start;
    } sswt_scan_ctrl_t;

    // Scan result back to the sequencer.
    typedef struct packed {
        logic done;
        logic hit;
    } sswt_scan_stat_t;

    // Map the window top to a word number, word 1 first.
    function automatic logic [2:0] word_of(input logic [11:0] top);
        logic [2:0] w;
        begin
            w = WORD_NONE;
            if (top == SW1_TOP)
            begin
                w = WORD_1;
            end
            else if (top == SW2_TOP)
            begin
                w = WORD_2;
            end
            else if (top == SW3_TOP)
            begin
                w = WORD_3;
            end
            else if (top == SW4_TOP)
            begin
                w = WORD_4;
            end
            return w;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/subframe_sync_word_tracker_unit.sv]
// Subframe sync word tracker. Each input item is one received bit: the top 12
// bits of the receive window and the bit counter. The tracker follows the sync
// word sequence 1-2-3-4-1 and returns one item of four pair flags per input
// item. An item passes the decide state, the scan state if a stamp search is
// needed, and the done state. A search runs when the second word of the current
// pair arrives: the stored stamps (at most STAMP_DEPTH) are read from the stamp
// memory one per cycle through a single subtract and compare. in_stall is high
// while an item is in work; a finished result waits in the output register and
// does not block the next item from being taken. The user writes subframe_bits
// through cfg_write/cfg_data while the block is idle, which it does not enforce.
`default_nettype none

module subframe_sync_word_tracker_unit #(
    parameter int STAMP_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [11:0] window_top,
    input  wire logic [31:0] bit_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       pair_flags
);

    localparam int AW = $clog2(STAMP_DEPTH);
    localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(STAMP_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DONE   = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [16:0] sub_reg, sub_next;
    logic [2:0]  track_reg, track_next;
    logic [AW:0] count_reg, count_next;
    logic [31:0] last_reg, last_next;
    logic [3:0]  flags_reg, flags_next;
    logic [2:0]  word_reg, word_next;
    logic [31:0] cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_flags_reg, out_flags_next;

    sswt_pkg::sswt_scan_ctrl_t scan_ctrl;
    sswt_pkg::sswt_scan_stat_t scan_stat;
    logic [AW-1:0] wr_addr;
    logic [2:0]    second;
    logic          has_room;
    logic [31:0]   loss_diff;
    logic          lost;
    logic [3:0]    flags_final;
    logic          out_free;

    sswt_stamp_scan #(
        .STAMP_DEPTH(STAMP_DEPTH),
        .AW(AW)
    ) u_scan (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(scan_ctrl),
        .wr_addr(wr_addr),
        .wr_data(cnt_reg),
        .stamp_count(count_reg),
        .cur_count(cnt_reg),
        .subframe_bits(sub_reg),
        .stat(scan_stat)
    );

    // Second word of the current pair, and the loss test.
    assign second      = (track_reg == sswt_pkg::TRK_P41) ? sswt_pkg::WORD_1
                                                          : track_reg + 3'd1;
    assign has_room    = (count_reg < DEPTH_CNT);
    assign loss_diff   = cnt_reg - last_reg;
    assign lost        = (loss_diff > {15'd0, sub_reg});
    assign flags_final = lost ? 4'd0 : flags_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign pair_flags = out_flags_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        sub_next       = sub_reg;
        track_next     = track_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        flags_next     = flags_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_flags_next = out_flags_reg;
        scan_ctrl      = '0;
        wr_addr        = count_reg[AW-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration write.
        if (cfg_write)
        begin
            sub_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = sswt_pkg::word_of(window_top);
                    cnt_next   = bit_count;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (track_reg == sswt_pkg::TRK_IDLE)
                begin
                    if (word_reg != sswt_pkg::WORD_NONE)
                    begin
                        scan_ctrl.wr_en = has_room;
                        if (has_room)
                        begin
                            count_next = count_reg + (AW + 1)'(1);
                        end
                        track_next = word_reg;
                    end
                end
                else if (track_reg <= sswt_pkg::TRK_P41)
                begin
                    if (word_reg == track_reg)
                    begin
                        scan_ctrl.wr_en = has_room;
                        if (has_room)
                        begin
                            count_next = count_reg + (AW + 1)'(1);
                        end
                    end
                    else if (word_reg == second)
                    begin
                        scan_ctrl.scan_start = 1'b1;
                        state_next           = S_SCAN;
                    end
                end
                else
                begin
                    track_next = sswt_pkg::TRK_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = S_DONE;
                    if (scan_stat.hit)
                    begin
                        // Confirmed: restart the store with this stamp.
                        scan_ctrl.wr_en = 1'b1;
                        wr_addr         = '0;
                        count_next      = (AW + 1)'(1);
                        last_next       = cnt_reg;
                        flags_next      = flags_reg | (4'd1 << (track_reg - 3'd1));
                        track_next      = second;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    flags_next     = flags_final;
                    out_flags_next = flags_final;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sub_reg       <= sswt_pkg::SUBFRAME_BITS_RST;
            track_reg     <= sswt_pkg::TRK_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sub_reg       <= sub_next;
            track_reg     <= track_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        cnt_reg       <= cnt_next;
        out_flags_reg <= out_flags_next;
    end

endmodule

`default_nettype wire

[rtl/sswt_stamp_scan.sv]
`default_nettype none

module sswt_stamp_scan #(
    parameter int STAMP_DEPTH = 128,
    parameter int AW = $clog2(STAMP_DEPTH)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sswt_pkg::sswt_scan_ctrl_t ctrl,
    input  wire logic [AW-1:0]           wr_addr,
    input  wire logic [31:0]             wr_data,
    input  wire logic [AW:0]             stamp_count,
    input  wire logic [31:0]             cur_count,
    input  wire logic [16:0]             subframe_bits,
    output sswt_pkg::sswt_scan_stat_t    stat
);

    logic [31:0]   mem [STAMP_DEPTH];
    logic [31:0]   rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic          active_reg, active_next;
    logic          pend_reg, pend_next;
    logic [AW:0]   idx_reg, idx_next;

    logic [31:0]   diff;
    logic          match;
    logic          more;

    // Stamp memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // The shared compare: one stored stamp per cycle.
    assign diff  = cur_count - rd_data_reg;
    assign match = (diff == {15'd0, subframe_bits});
    assign more  = (idx_reg < stamp_count);

    always_comb
    begin
        active_next = active_reg;
        pend_next   = 1'b0;
        idx_next    = idx_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        stat.done   = 1'b0;
        stat.hit    = 1'b0;
        if (ctrl.scan_start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            if (pend_reg && match)
            begin
                stat.done   = 1'b1;
                stat.hit    = 1'b1;
                active_next = 1'b0;
            end
            else if (!pend_reg && !more)
            begin
                stat.done   = 1'b1;
                active_next = 1'b0;
            end
            else if (more)
            begin
                rd_en     = 1'b1;
                pend_next = 1'b1;
                idx_next  = idx_reg + (AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sswt_checker.sv]
`default_nettype none

module sswt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [3:0] pair_flags
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pair_flags))
        else $error("stalled result item changed");

    // After an item is taken the block is busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accepting an item");

    // A new result only appears at the end of work on an item.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result item without an item in work");

    // Finishing an item always leaves a result.
    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("item finished without a result");

endmodule

bind subframe_sync_word_tracker_unit sswt_checker u_sswt_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pair_flags(pair_flags)
);

`default_nettype wire
